FILE: rtl/bthd_pkg.sv
package bthd_pkg;

    localparam int CFG_W     = 16;
    localparam int CFG_IDX_W = 8;
    localparam int TALLY_W   = 2;

    typedef logic [CFG_IDX_W-1:0] t_cfg_idx;

    localparam t_cfg_idx CFG_HOLD_TIME     = t_cfg_idx'(0);
    localparam t_cfg_idx CFG_CLICK_MAX     = t_cfg_idx'(1);
    localparam t_cfg_idx CFG_DEBOUNCE_MIN  = t_cfg_idx'(2);
    localparam t_cfg_idx CFG_TRIPLE_WINDOW = t_cfg_idx'(3);

    localparam logic [CFG_W-1:0] HOLD_TIME_RST     = 16'd3000;
    localparam logic [CFG_W-1:0] CLICK_MAX_RST     = 16'd600;
    localparam logic [CFG_W-1:0] DEBOUNCE_MIN_RST  = 16'd40;
    localparam logic [CFG_W-1:0] TRIPLE_WINDOW_RST = 16'd1500;

    // the click that completes a triple
    localparam logic [TALLY_W-1:0] TRIPLE_COUNT = 2'd3;

    typedef struct packed {
        logic [CFG_W-1:0] hold_time;
        logic [CFG_W-1:0] click_max;
        logic [CFG_W-1:0] debounce_min;
        logic [CFG_W-1:0] triple_window;
    } t_cfg;

    typedef struct packed {
        logic button_level;
        logic ap_active;
    } t_in_word;

    typedef struct packed {
        logic               hold_event;
        logic               click_event;
        logic               triple_event;
        logic [TALLY_W-1:0] clicks_so_far;
    } t_out_word;

endpackage

FILE: rtl/bthd_stream_if.sv
interface bthd_stream_if #(
    parameter type T = logic
);
    logic valid;
    logic ready;
    T     data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

FILE: rtl/bthd_cfg.sv
module bthd_cfg (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_cfg_we,
    input  logic [bthd_pkg::CFG_IDX_W-1:0]   i_cfg_idx,
    input  logic [bthd_pkg::CFG_W-1:0]       i_cfg_data,
    output bthd_pkg::t_cfg                   o_cfg
);
    bthd_pkg::t_cfg r_cfg;
    bthd_pkg::t_cfg n_cfg;

    always_comb begin
        n_cfg = r_cfg;
        if (i_cfg_we) begin
            case (i_cfg_idx)
                bthd_pkg::CFG_HOLD_TIME:     n_cfg.hold_time     = i_cfg_data;
                bthd_pkg::CFG_CLICK_MAX:     n_cfg.click_max     = i_cfg_data;
                bthd_pkg::CFG_DEBOUNCE_MIN:  n_cfg.debounce_min  = i_cfg_data;
                bthd_pkg::CFG_TRIPLE_WINDOW: n_cfg.triple_window = i_cfg_data;
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.hold_time     <= bthd_pkg::HOLD_TIME_RST;
            r_cfg.click_max     <= bthd_pkg::CLICK_MAX_RST;
            r_cfg.debounce_min  <= bthd_pkg::DEBOUNCE_MIN_RST;
            r_cfg.triple_window <= bthd_pkg::TRIPLE_WINDOW_RST;
        end else begin
            r_cfg <= n_cfg;
        end
    end

    assign o_cfg = r_cfg;
endmodule

FILE: rtl/bthd_core.sv
module bthd_core #(
    parameter int TIME_BITS = 16
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_fire,
    input  bthd_pkg::t_in_word    i_word,
    input  bthd_pkg::t_cfg        i_cfg,
    output bthd_pkg::t_out_word   o_result
);
    localparam int CMP_W = (TIME_BITS > bthd_pkg::CFG_W) ? TIME_BITS : bthd_pkg::CFG_W;

    logic                          r_held;
    logic [TIME_BITS-1:0]          r_press_age;
    logic [bthd_pkg::TALLY_W-1:0]  r_click_tally;
    logic [TIME_BITS-1:0]          r_window_age;

    logic                          n_held;
    logic [TIME_BITS-1:0]          n_press_age;
    logic [bthd_pkg::TALLY_W-1:0]  n_click_tally;
    logic [TIME_BITS-1:0]          n_window_age;

    logic [TIME_BITS-1:0]          press_inc;
    logic [TIME_BITS-1:0]          window_inc;
    logic [bthd_pkg::TALLY_W-1:0]  tally_base;
    logic [bthd_pkg::TALLY_W-1:0]  tally_plus;
    logic                          restart;
    logic                          is_click;
    logic                          hold_ev;
    logic                          click_ev;
    logic                          triple_ev;

    // saturating ages
    assign window_inc = (&r_window_age) ? r_window_age : r_window_age + TIME_BITS'(1);
    assign press_inc  = (!r_held || (&r_press_age)) ? r_press_age
                                                    : r_press_age + TIME_BITS'(1);

    assign is_click = (CMP_W'(press_inc) >= CMP_W'(i_cfg.debounce_min))
                   && (CMP_W'(press_inc) <  CMP_W'(i_cfg.click_max));
    assign restart  = (r_click_tally == '0)
                   || (CMP_W'(window_inc) > CMP_W'(i_cfg.triple_window));
    assign tally_base = restart ? '0 : r_click_tally;
    assign tally_plus = tally_base + {{(bthd_pkg::TALLY_W-1){1'b0}}, 1'b1};

    always_comb begin
        n_held        = r_held;
        n_press_age   = press_inc;
        n_click_tally = r_click_tally;
        n_window_age  = window_inc;
        hold_ev       = 1'b0;
        click_ev      = 1'b0;
        triple_ev     = 1'b0;
        if (!i_word.button_level) begin
            n_held = 1'b1;
            if (!r_held) begin
                n_press_age = '0;
            end
            if (!i_word.ap_active && (CMP_W'(n_press_age) >= CMP_W'(i_cfg.hold_time))) begin
                hold_ev       = 1'b1;
                n_click_tally = '0;
            end
        end else if (r_held) begin
            n_held = 1'b0;
            if (is_click) begin
                click_ev = 1'b1;
                if (restart) begin
                    n_window_age = '0;
                end
                if (tally_plus == bthd_pkg::TRIPLE_COUNT) begin
                    triple_ev     = 1'b1;
                    n_click_tally = '0;
                end else begin
                    n_click_tally = tally_plus;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_held        <= 1'b0;
            r_press_age   <= '0;
            r_click_tally <= '0;
            r_window_age  <= '0;
        end else if (i_fire) begin
            r_held        <= n_held;
            r_press_age   <= n_press_age;
            r_click_tally <= n_click_tally;
            r_window_age  <= n_window_age;
        end
    end

    assign o_result.hold_event    = hold_ev;
    assign o_result.click_event   = click_ev;
    assign o_result.triple_event  = triple_ev;
    assign o_result.clicks_so_far = n_click_tally;

    a_tally_below_three: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_click_tally != bthd_pkg::TRIPLE_COUNT)
        else $error("click tally reached three");

    a_triple_is_click: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        triple_ev |-> click_ev && (n_click_tally == '0))
        else $error("triple without a click");

    a_press_sets_held: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_fire && !i_word.button_level && !r_held |=> r_held && (r_press_age == '0))
        else $error("press start not recorded");

    a_hold_excludes_click: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(hold_ev && click_ev))
        else $error("hold and click in one tick");
endmodule

FILE: rtl/button_hold_and_triple_click_detector.sv
// Button hold / triple-click detector, one tick word per millisecond.
// i_tick carries one word per tick: button_level (active low) and ap_active.
// o_evt returns exactly one word per tick: hold_event, click_event,
// triple_event and clicks_so_far (click count after that tick).
// Both channels use valid/ready; a word moves when both are high.
// A tick accepted into the input register moves through the core into the
// result register once that register is free. Throughput is one tick per
// cycle while o_evt does not stall: the state update is a single pass of
// saturating increments and compares between input and result registers.
// When o_evt stalls, the pending result holds, the input register keeps one
// more tick and i_tick.ready drops; nothing is lost or repeated.
// The config port writes hold_time, click_max, debounce_min and
// triple_window (index 0 to 3, other indexes ignored); write only when idle.
// Synchronous reset clears the press and click state, empties both
// registers and loads the default config values.
module button_hold_and_triple_click_detector #(
    parameter int TIME_BITS = 16
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_cfg_we,
    input  logic [bthd_pkg::CFG_IDX_W-1:0]   i_cfg_idx,
    input  logic [bthd_pkg::CFG_W-1:0]       i_cfg_data,
    bthd_stream_if.sink                      i_tick,
    bthd_stream_if.source                    o_evt
);
    bthd_pkg::t_cfg       cfg;
    bthd_pkg::t_out_word  core_result;

    logic                 r_in_valid;
    bthd_pkg::t_in_word   r_in_word;
    logic                 r_out_valid;
    bthd_pkg::t_out_word  r_out_word;
    logic                 advance;

    bthd_cfg u_cfg (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .o_cfg      (cfg)
    );

    // word leaves the input register when the result register can take it
    assign advance      = r_in_valid && (!r_out_valid || o_evt.ready);
    assign i_tick.ready = !r_in_valid || advance;

    bthd_core #(
        .TIME_BITS (TIME_BITS)
    ) u_core (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_fire   (advance),
        .i_word   (r_in_word),
        .i_cfg    (cfg),
        .o_result (core_result)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_tick.ready) begin
                r_in_valid <= i_tick.valid;
            end
            if (advance) begin
                r_out_valid <= 1'b1;
            end else if (o_evt.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_tick.valid && i_tick.ready) begin
            r_in_word <= i_tick.data;
        end
        if (advance) begin
            r_out_word <= core_result;
        end
    end

    assign o_evt.valid = r_out_valid;
    assign o_evt.data  = r_out_word;
endmodule

FILE: sim/button_hold_and_triple_click_detector_tb.sv
`timescale 1ns / 100ps

module button_hold_and_triple_click_detector_tb;

    localparam int AGE_W = 16;
    localparam int unsigned CYCLE_LIMIT = 200_000;
    localparam bthd_pkg::t_cfg_idx CFG_SPARE_IDX = bthd_pkg::t_cfg_idx'(4);
    localparam bthd_pkg::t_cfg_idx CFG_TOP_IDX = '1;
    localparam logic [bthd_pkg::CFG_W-1:0] CFG_ALL_ONES = '1;

    typedef enum {AP_CLEAR, AP_SET, AP_RANDOM} t_ap_mode;
    typedef enum {RX_OPEN, RX_COIN, RX_EVERY_FOURTH, RX_TRICKLE} t_rx_mode;

    class press_tracker;
        bthd_pkg::t_cfg cfg;
        logic held;
        logic [AGE_W-1:0] press_age;
        logic [AGE_W-1:0] window_age;
        logic [bthd_pkg::TALLY_W-1:0] tally;
        bthd_pkg::t_out_word events_due[$];
        int n_bad;

        function new();
            cfg.hold_time = bthd_pkg::HOLD_TIME_RST;
            cfg.click_max = bthd_pkg::CLICK_MAX_RST;
            cfg.debounce_min = bthd_pkg::DEBOUNCE_MIN_RST;
            cfg.triple_window = bthd_pkg::TRIPLE_WINDOW_RST;
            held = 1'b0;
            press_age = '0;
            window_age = '0;
            tally = '0;
            n_bad = 0;
        endfunction

        task flag(string msg);
            $display("mismatch at %0t: %s", $time, msg);
            n_bad++;
        endtask

        function void set_reg(bthd_pkg::t_cfg_idx idx, logic [bthd_pkg::CFG_W-1:0] val);
            case (idx)
                bthd_pkg::CFG_HOLD_TIME: cfg.hold_time = val;
                bthd_pkg::CFG_CLICK_MAX: cfg.click_max = val;
                bthd_pkg::CFG_DEBOUNCE_MIN: cfg.debounce_min = val;
                bthd_pkg::CFG_TRIPLE_WINDOW: cfg.triple_window = val;
                default: ;
            endcase
        endfunction

        function logic [AGE_W-1:0] bump(logic [AGE_W-1:0] v);
            return (v == '1) ? v : v + AGE_W'(1);
        endfunction

        function void take_tick(bthd_pkg::t_in_word w);
            bthd_pkg::t_out_word ev;
            ev = '0;
            window_age = bump(window_age);
            if (held) press_age = bump(press_age);
            if (!w.button_level) begin
                if (!held) begin
                    held = 1'b1;
                    press_age = '0;
                end
                if (!w.ap_active && press_age >= cfg.hold_time) begin
                    ev.hold_event = 1'b1;
                    tally = '0;
                end
            end else if (held) begin
                held = 1'b0;
                if (press_age >= cfg.debounce_min && press_age < cfg.click_max) begin
                    // first click, or one after the window closed, opens a new window
                    if (tally == '0 || window_age > cfg.triple_window) begin
                        tally = '0;
                        window_age = '0;
                    end
                    tally++;
                    ev.click_event = 1'b1;
                    if (tally >= bthd_pkg::TRIPLE_COUNT) begin
                        tally = '0;
                        ev.triple_event = 1'b1;
                    end
                end
            end
            ev.clicks_so_far = tally;
            events_due.push_back(ev);
        endfunction

        task match_event(bthd_pkg::t_out_word got);
            bthd_pkg::t_out_word want;
            if (events_due.size() == 0) begin
                flag($sformatf("event word %h with no tick pending", got));
                return;
            end
            want = events_due.pop_front();
            if (got.hold_event !== want.hold_event)
                flag($sformatf("hold_event %b, want %b", got.hold_event, want.hold_event));
            if (got.click_event !== want.click_event)
                flag($sformatf("click_event %b, want %b", got.click_event, want.click_event));
            if (got.triple_event !== want.triple_event)
                flag($sformatf("triple_event %b, want %b", got.triple_event, want.triple_event));
            if (got.clicks_so_far !== want.clicks_so_far)
                flag($sformatf("clicks_so_far %0d, want %0d",
                               got.clicks_so_far, want.clicks_so_far));
        endtask

        function int pending();
            return events_due.size();
        endfunction
    endclass

    logic i_clk = 1'b0;
    logic i_rst_n;
    logic i_cfg_we;
    bthd_pkg::t_cfg_idx i_cfg_idx;
    logic [bthd_pkg::CFG_W-1:0] i_cfg_data;

    bthd_stream_if #(.T(bthd_pkg::t_in_word)) tick_if ();
    bthd_stream_if #(.T(bthd_pkg::t_out_word)) evt_if ();

    press_tracker tracker;
    int unsigned ticks_sent;
    int burst_left;
    int rx_left;
    int unsigned rx_phase;
    t_rx_mode rx_mode;

    button_hold_and_triple_click_detector #(
        .TIME_BITS(AGE_W)
    ) i_dut (
        .i_clk(i_clk),
        .i_rst_n(i_rst_n),
        .i_cfg_we(i_cfg_we),
        .i_cfg_idx(i_cfg_idx),
        .i_cfg_data(i_cfg_data),
        .i_tick(tick_if),
        .o_evt(evt_if)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // receiver stalls: the ready pattern is redrawn from four modes after each run
    always @(posedge i_clk) begin
        if (rx_left == 0) begin
            rx_left = $urandom_range(20, 400);
            rx_mode = t_rx_mode'($urandom_range(0, 3));
        end
        rx_left--;
        rx_phase++;
        case (rx_mode)
            RX_OPEN: evt_if.ready <= 1'b1;
            RX_COIN: evt_if.ready <= 1'($urandom_range(0, 1));
            RX_EVERY_FOURTH: evt_if.ready <= (rx_phase % 4 == 0);
            default: evt_if.ready <= ($urandom_range(0, 7) == 0);
        endcase
    end

    // event words are checked before the tick word of the same edge is noted
    always @(posedge i_clk) begin
        if (i_rst_n === 1'b1) begin
            if (evt_if.valid && evt_if.ready) tracker.match_event(evt_if.data);
            if (tick_if.valid && tick_if.ready) tracker.take_tick(tick_if.data);
        end
    end

    task automatic send_tick(bthd_pkg::t_in_word w);
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 64);
            if ($urandom_range(0, 3) != 0) begin
                tick_if.valid <= 1'b0;
                repeat ($urandom_range(1, 6)) @(posedge i_clk);
            end
        end
        tick_if.valid <= 1'b1;
        tick_if.data <= w;
        @(posedge i_clk);
        while (!tick_if.ready) @(posedge i_clk);
        burst_left--;
        ticks_sent++;
    endtask

    task automatic press(int unsigned len, t_ap_mode mode);
        bthd_pkg::t_in_word w;
        for (int unsigned k = 0; k < len; k++) begin
            w.button_level = 1'b0;
            w.ap_active = (mode == AP_RANDOM) ? 1'($urandom_range(0, 1)) : (mode == AP_SET);
            send_tick(w);
        end
    endtask

    task automatic let_go(int unsigned len);
        bthd_pkg::t_in_word w;
        for (int unsigned k = 0; k < len; k++) begin
            w.button_level = 1'b1;
            w.ap_active = 1'($urandom_range(0, 1));
            send_tick(w);
        end
    endtask

    task automatic drain();
        tick_if.valid <= 1'b0;
        @(posedge i_clk);
        while (tracker.pending() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic write_reg(bthd_pkg::t_cfg_idx idx, logic [bthd_pkg::CFG_W-1:0] val);
        i_cfg_we <= 1'b1;
        i_cfg_idx <= idx;
        i_cfg_data <= val;
        @(posedge i_clk);
        tracker.set_reg(idx, val);
    endtask

    task automatic apply_cfg(logic [bthd_pkg::CFG_W-1:0] hold,
                             logic [bthd_pkg::CFG_W-1:0] cmax,
                             logic [bthd_pkg::CFG_W-1:0] deb,
                             logic [bthd_pkg::CFG_W-1:0] win);
        write_reg(bthd_pkg::CFG_HOLD_TIME, hold);
        write_reg(bthd_pkg::CFG_CLICK_MAX, cmax);
        write_reg(bthd_pkg::CFG_DEBOUNCE_MIN, deb);
        write_reg(bthd_pkg::CFG_TRIPLE_WINDOW, win);
        i_cfg_we <= 1'b0;
    endtask

    // mostly press/release sequences sized around the current limits
    task automatic run_random(int unsigned n);
        int unsigned stop_at, lo, hi, win, len, kind;
        stop_at = ticks_sent + n;
        while (ticks_sent < stop_at) begin
            lo = (tracker.cfg.debounce_min > 0) ? tracker.cfg.debounce_min : 1;
            hi = tracker.cfg.click_max;
            win = tracker.cfg.triple_window;
            kind = $urandom_range(0, 9);
            if (kind <= 6) begin
                if (kind <= 4) begin
                    len = (hi > lo) ? $urandom_range(lo, hi - 1) : $urandom_range(1, hi + 2);
                end else if (kind == 5) begin
                    case ($urandom_range(0, 3))
                        0: len = lo;
                        1: len = (lo > 1) ? lo - 1 : 1;
                        2: len = (hi > 0) ? hi : 1;
                        default: len = hi + 1;
                    endcase
                end else begin
                    len = tracker.cfg.hold_time + $urandom_range(0, 4);
                    if (len == 0) len = 1;
                end
                press(len, t_ap_mode'($urandom_range(0, 2)));
                if ($urandom_range(0, 4) != 0) let_go($urandom_range(1, win + 1));
                else let_go($urandom_range(win + 1, win + 8));
            end else if (kind == 7) begin
                repeat ($urandom_range(1, 8))
                    send_tick(bthd_pkg::t_in_word'($urandom_range(0, 3)));
            end else begin
                let_go($urandom_range(1, win + 8));
            end
        end
    endtask

    initial begin
        int unsigned cycles;
        cycles = 0;
        while (cycles < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycles++;
        end
        $display("[FAIL] regression broken");
        $finish;
    end

    initial begin
        tracker = new();
        i_rst_n = 1'b0;
        i_cfg_we = 1'b0;
        i_cfg_idx = bthd_pkg::CFG_HOLD_TIME;
        i_cfg_data = '0;
        tick_if.valid = 1'b0;
        tick_if.data = '0;
        evt_if.ready = 1'b0;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // limits after reset: a 45 tick press clicks, a 30 tick one does not
        press(45, AP_RANDOM);
        let_go(3);
        press(30, AP_RANDOM);
        let_go(3);
        drain();

        apply_cfg(3, 4, 1, 6);
        let_go(1);
        press(1, AP_SET);
        let_go(1);
        press(2, AP_SET);
        let_go(1);
        press(1, AP_SET);       // third click in the window
        let_go(1);
        press(4, AP_CLEAR);     // hold on the fourth tick, too long for a click
        let_go(1);
        press(4, AP_SET);       // same press with hold suppressed
        let_go(1);
        press(1, AP_SET);
        let_go(7);              // window runs out before the next click
        press(1, AP_SET);
        let_go(1);
        drain();

        apply_cfg(0, 5, 0, 10);     // hold fires on the first pressed tick
        run_random(160);
        drain();
        apply_cfg(8, 6, 2, 0);      // window closes at once, no triples
        run_random(140);
        drain();
        apply_cfg(1, 1, 5, 3);      // empty click range
        run_random(100);
        drain();
        write_reg(CFG_SPARE_IDX, CFG_ALL_ONES);
        write_reg(CFG_TOP_IDX, '0);
        apply_cfg(12, 10, 3, 30);
        run_random(200);
        drain();
        repeat (3) begin
            apply_cfg($urandom_range(0, 20), $urandom_range(1, 16),
                      $urandom_range(0, 8), $urandom_range(0, 40));
            run_random(120);
            drain();
        end
        apply_cfg('0, '0, '0, '0);
        run_random(40);
        drain();

        if (tracker.n_bad == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

endmodule

FILE: button_hold_and_triple_click_detector.f
rtl/bthd_pkg.sv
rtl/bthd_stream_if.sv
rtl/bthd_cfg.sv
rtl/bthd_core.sv
rtl/button_hold_and_triple_click_detector.sv
sim/button_hold_and_triple_click_detector_tb.sv
